// ===== sv/rld_pkg.sv =====
package rld_pkg;

  // Fixed formats of the fields and of the internal arithmetic.
  localparam int COORD_FRAC_BITS = 16;
  localparam int MAX_ITERATIONS  = 64;
  localparam int ITER_W          = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int COORD_W         = 32;
  localparam int COEFF_W         = 32;
  localparam int SIZE_W          = 15;
  localparam int RATIO_W         = 24;
  localparam int RATIO_FRAC      = 16;
  localparam int IDX_W           = 3;
  localparam int Q_SHIFT         = 30;
  localparam int OPND_W          = 64;
  localparam int PROD_W          = 2 * OPND_W;
  localparam int DIV_W           = 63;
  localparam int DIV_CNT_W       = $clog2(DIV_W);
  localparam int CENTER_W        = SIZE_W + COORD_FRAC_BITS - 1;
  localparam int R2_SHIFT        = 2 * COORD_FRAC_BITS - 10;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int SUM_W           = SQ_W + 1;
  localparam int S_W             = SUM_W - R2_SHIFT;

  localparam logic signed [63:0] POLY_LIM  = 64'sd1 <<< 62;
  localparam logic signed [63:0] DIV_LIM   = 64'sd1 <<< 44;
  localparam logic signed [63:0] ONE_Q30   = 64'sd1 <<< Q_SHIFT;
  localparam logic signed [63:0] TOLERANCE = (64'sd1 <<< COORD_FRAC_BITS) / 10;

  localparam logic [SIZE_W-1:0]  WIDTH_RST = 15'd1920;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 15'd1080;
  localparam logic [RATIO_W-1:0] RATIO_RST = 24'd65536;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_COEFF_FIRST  = 3'd0,
    REG_COEFF_SECOND = 3'd1,
    REG_COEFF_THIRD  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4,
    REG_SCALE_RATIO  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mapped_x;
    logic signed [COORD_W-1:0] mapped_y;
    logic                      converged;
  } out_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_first;
    logic signed [COEFF_W-1:0] coeff_second;
    logic signed [COEFF_W-1:0] coeff_third;
    logic [SIZE_W-1:0]         image_width;
    logic [SIZE_W-1:0]         image_height;
    logic [RATIO_W-1:0]        scale_ratio;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CMUL,
    OP_CSUB,
    OP_SQ,
    OP_SSUM,
    OP_PMUL,
    OP_PADD,
    OP_EMUL,
    OP_ESET,
    OP_QDIV,
    OP_QSET,
    OP_FWDSET,
    OP_STEP,
    OP_ODIV,
    OP_OSET_PUB
  } op_e;

  localparam op_e OP_OSET    = OP_OSET_PUB;

  // Coefficient added after each Horner multiply.
  typedef enum logic [1:0] {
    KSEL_SECOND,
    KSEL_FIRST,
    KSEL_ONE
  } ksel_e;

  typedef struct packed {
    op_e   op;
    logic  axis;
    ksel_e ksel;
    logic  publish;
  } ctrl_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic a_pos;
    logic conv;
    logic inverse;
  } stat_t;

  // Saturate to signed 32 bit.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Saturate to plus or minus a limit.
  function automatic logic signed [63:0] clamp_lim(input logic signed [65:0] v,
                                                   input logic signed [63:0] lim);
    logic signed [63:0] r;
    if (v > 66'(lim)) begin
      r = lim;
    end else if (v < -66'(lim)) begin
      r = -lim;
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/rld_mul.sv =====
module rld_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rld_pkg::OPND_W-1:0]     a_i,
  input  logic [rld_pkg::OPND_W-1:0]     b_i,
  output logic                           done_o,
  output logic [rld_pkg::PROD_W-1:0]     prod_o
);

  localparam int HALF_W = rld_pkg::OPND_W / 2;

  logic [rld_pkg::OPND_W-1:0] a_q, b_q;
  logic [rld_pkg::PROD_W-1:0] acc_q;
  logic [1:0]                 step_q;
  logic                       busy_q, done_q;

  logic [HALF_W-1:0]          a_half, b_half;
  logic [rld_pkg::OPND_W-1:0] pp;
  logic [1:0]                 pos;
  logic [rld_pkg::PROD_W-1:0] pp_shifted;

  // One 32x32 partial product per cycle, placed by the sum of the half indexes.
  always_comb begin
    a_half     = step_q[0] ? a_q[rld_pkg::OPND_W-1:HALF_W] : a_q[HALF_W-1:0];
    b_half     = step_q[1] ? b_q[rld_pkg::OPND_W-1:HALF_W] : b_q[HALF_W-1:0];
    pp         = a_half * b_half;
    pos        = 2'({1'b0, step_q[0]} + {1'b0, step_q[1]});
    pp_shifted = rld_pkg::PROD_W'(pp) << (pos * HALF_W);
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_shifted;
    end
  end

  // Step sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (start_i) begin
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/rld_div.sv =====
module rld_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rld_pkg::DIV_W-1:0]  num_i,
  input  logic [rld_pkg::OPND_W-1:0] den_i,
  output logic                       done_o,
  output logic [rld_pkg::DIV_W-1:0]  quot_o
);

  logic [rld_pkg::DIV_W-1:0]     num_q, quo_q;
  logic [rld_pkg::OPND_W-1:0]    den_q;
  logic [rld_pkg::OPND_W:0]      rem_q;
  logic [rld_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;

  logic [rld_pkg::OPND_W:0]      rem_sh;
  logic                          fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem_q[rld_pkg::OPND_W-1:0], num_q[rld_pkg::DIV_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[rld_pkg::DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        cnt_q  <= rld_pkg::DIV_CNT_W'(rld_pkg::DIV_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/rld_dp.sv =====
module rld_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rld_pkg::ctrl_t ctrl_i,
  input  rld_pkg::cfg_t  cfg_i,
  input  rld_pkg::in_t   in_data_i,
  output rld_pkg::stat_t stat_o,
  output rld_pkg::out_t  out_data_o
);

  localparam int CW     = rld_pkg::COORD_W;
  localparam int Q_BITS = rld_pkg::Q_SHIFT;

  // Payload registers.
  logic                              cmd_q;
  logic signed [CW-1:0]              px_q, py_q, sx_q, sy_q, vx_q, vy_q, ox_q, oy_q;
  logic signed [CW+rld_pkg::RATIO_W:0] cpx_q, cpy_q;
  logic [rld_pkg::SQ_W-1:0]          sqx_q, sqy_q;
  logic [rld_pkg::S_W-1:0]           s_q;
  logic signed [63:0]                t_q, qx_q, qy_q, rx_q, ry_q;
  logic                              mneg_q, qneg_q, ok_q, conv_q;
  rld_pkg::out_t                     res_q;

  // Unit interfaces.
  logic                              mul_start, mul_done, div_start, div_done;
  logic [rld_pkg::OPND_W-1:0]        mul_a, mul_b, div_den;
  logic [rld_pkg::PROD_W-1:0]        mul_prod;
  logic [rld_pkg::DIV_W-1:0]         div_num, div_quot;
  logic                              neg_d;

  // Derived values.
  logic [rld_pkg::RATIO_W-1:0]       ratio_eff;
  logic [rld_pkg::CENTER_W-1:0]      ctr_x, ctr_y, ctr_sel;
  logic [CW-1:0]                     ux, uy, usx, usy, un;
  logic [63:0]                       ut, mmag, uw, quot64;
  logic [rld_pkg::PROD_W-Q_BITS-1:0] pq;
  logic signed [63:0]                ms, kval, q_val, dx, dy, rsel, w, ov;
  logic signed [CW-1:0]              nsel, ssel;
  logic                              conv_d;

  assign ratio_eff = (cfg_i.scale_ratio == '0) ? rld_pkg::RATIO_W'(1) : cfg_i.scale_ratio;
  assign ctr_x = {cfg_i.image_width, {(rld_pkg::COORD_FRAC_BITS - 1){1'b0}}};
  assign ctr_y = {cfg_i.image_height, {(rld_pkg::COORD_FRAC_BITS - 1){1'b0}}};

  // Magnitudes of the working values.
  always_comb begin
    ux  = vx_q[CW-1] ? (~vx_q + 1'b1) : vx_q;
    uy  = vy_q[CW-1] ? (~vy_q + 1'b1) : vy_q;
    usx = sx_q[CW-1] ? (~sx_q + 1'b1) : sx_q;
    usy = sy_q[CW-1] ? (~sy_q + 1'b1) : sy_q;
    ut  = t_q[63] ? (~t_q + 1'b1) : t_q;
    nsel = ctrl_i.axis ? vy_q : vx_q;
    ssel = ctrl_i.axis ? sy_q : sx_q;
    un   = nsel[CW-1] ? (~nsel + 1'b1) : nsel;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_start = (ctrl_i.op == rld_pkg::OP_PMUL) || (ctrl_i.op == rld_pkg::OP_EMUL);
    mul_b     = ut;
    if (ctrl_i.op == rld_pkg::OP_EMUL) begin
      mul_a = rld_pkg::OPND_W'(ctrl_i.axis ? usy : usx);
      neg_d = ssel[CW-1] ^ t_q[63];
    end else begin
      mul_a = rld_pkg::OPND_W'(s_q);
      neg_d = t_q[63];
    end
  end

  // Product shifted by 30, saturated, signed.
  always_comb begin
    pq   = mul_prod[rld_pkg::PROD_W-1:Q_BITS];
    mmag = (pq > ($bits(pq))'(rld_pkg::POLY_LIM)) ? rld_pkg::POLY_LIM : pq[63:0];
    ms   = mneg_q ? -$signed(mmag) : $signed(mmag);
    case (ctrl_i.ksel)
      rld_pkg::KSEL_SECOND: kval = 64'(cfg_i.coeff_second);
      rld_pkg::KSEL_FIRST:  kval = 64'(cfg_i.coeff_first);
      default:              kval = rld_pkg::ONE_Q30;
    endcase
  end

  // Shared divider operand selection: quotient of the point, or output scaling.
  always_comb begin
    rsel    = ctrl_i.axis ? ry_q : rx_q;
    ctr_sel = ctrl_i.axis ? ctr_y : ctr_x;
    w       = rld_pkg::clamp_lim(66'(rsel), rld_pkg::DIV_LIM)
              + 64'($signed({1'b0, ctr_sel}));
    uw      = w[63] ? (~w + 1'b1) : w;
    div_start = (ctrl_i.op == rld_pkg::OP_QDIV) || (ctrl_i.op == rld_pkg::OP_ODIV);
    if (ctrl_i.op == rld_pkg::OP_ODIV) begin
      div_num = rld_pkg::DIV_W'(uw << rld_pkg::RATIO_FRAC);
      div_den = rld_pkg::OPND_W'(ratio_eff);
    end else begin
      div_num = rld_pkg::DIV_W'({un, {Q_BITS{1'b0}}});
      div_den = t_q;
    end
  end

  // Quotient results and the correction step.
  always_comb begin
    quot64 = 64'(div_quot);
    ov     = qneg_q ? -$signed(quot64) : $signed(quot64);
    if (t_q <= 64'sd0) begin
      if (nsel > 32'sd0) begin
        q_val = rld_pkg::DIV_LIM;
      end else if (nsel < 32'sd0) begin
        q_val = -rld_pkg::DIV_LIM;
      end else begin
        q_val = 64'sd0;
      end
    end else begin
      q_val = ov;
    end
    dx     = 64'(sx_q) - qx_q;
    dy     = 64'(sy_q) - qy_q;
    conv_d = (dx > -rld_pkg::TOLERANCE) && (dx < rld_pkg::TOLERANCE) &&
             (dy > -rld_pkg::TOLERANCE) && (dy < rld_pkg::TOLERANCE);
  end

  // Datapath register updates.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      rld_pkg::OP_LOAD: begin
        cmd_q <= in_data_i.command;
        px_q  <= in_data_i.point_x;
        py_q  <= in_data_i.point_y;
      end
      rld_pkg::OP_CMUL: begin
        cpx_q <= px_q * $signed({1'b0, ratio_eff});
        cpy_q <= py_q * $signed({1'b0, ratio_eff});
      end
      rld_pkg::OP_CSUB: begin
        sx_q <= rld_pkg::sat32(66'(cpx_q >>> rld_pkg::RATIO_FRAC) - 66'($signed({1'b0, ctr_x})));
        sy_q <= rld_pkg::sat32(66'(cpy_q >>> rld_pkg::RATIO_FRAC) - 66'($signed({1'b0, ctr_y})));
        vx_q <= rld_pkg::sat32(66'(cpx_q >>> rld_pkg::RATIO_FRAC) - 66'($signed({1'b0, ctr_x})));
        vy_q <= rld_pkg::sat32(66'(cpy_q >>> rld_pkg::RATIO_FRAC) - 66'($signed({1'b0, ctr_y})));
      end
      rld_pkg::OP_SQ: begin
        sqx_q <= ux * ux;
        sqy_q <= uy * uy;
      end
      rld_pkg::OP_SSUM: begin
        s_q <= rld_pkg::S_W'((rld_pkg::SUM_W'(sqx_q) + rld_pkg::SUM_W'(sqy_q))
                             >> rld_pkg::R2_SHIFT);
        t_q <= 64'(cfg_i.coeff_third);
      end
      rld_pkg::OP_PMUL, rld_pkg::OP_EMUL: begin
        mneg_q <= neg_d;
      end
      rld_pkg::OP_PADD: begin
        t_q <= rld_pkg::clamp_lim(66'(ms) + 66'(kval), rld_pkg::POLY_LIM);
      end
      rld_pkg::OP_ESET: begin
        if (ctrl_i.axis) begin
          vy_q <= rld_pkg::sat32(66'(ms));
          ry_q <= 64'(rld_pkg::sat32(66'(ms)));
        end else begin
          vx_q <= rld_pkg::sat32(66'(ms));
          rx_q <= 64'(rld_pkg::sat32(66'(ms)));
        end
      end
      rld_pkg::OP_QDIV, rld_pkg::OP_ODIV: begin
        qneg_q <= (ctrl_i.op == rld_pkg::OP_ODIV) ? w[63] : nsel[CW-1];
      end
      rld_pkg::OP_QSET: begin
        if (ctrl_i.axis) begin
          qy_q <= q_val;
        end else begin
          qx_q <= q_val;
        end
      end
      rld_pkg::OP_FWDSET: begin
        rx_q <= qx_q;
        ry_q <= qy_q;
        ok_q <= t_q > 64'sd0;
      end
      rld_pkg::OP_STEP: begin
        vx_q   <= rld_pkg::sat32(66'(vx_q) + 66'(dx));
        vy_q   <= rld_pkg::sat32(66'(vy_q) + 66'(dy));
        rx_q   <= 64'(rld_pkg::sat32(66'(vx_q) + 66'(dx)));
        ry_q   <= 64'(rld_pkg::sat32(66'(vy_q) + 66'(dy)));
        ok_q   <= conv_d;
        conv_q <= conv_d;
      end
      rld_pkg::OP_OSET: begin
        if (ctrl_i.axis) begin
          oy_q <= rld_pkg::sat32(66'(ov));
        end else begin
          ox_q <= rld_pkg::sat32(66'(ov));
        end
      end
      default: begin
      end
    endcase
    // Result register, loaded only when the output side is free.
    if (ctrl_i.publish) begin
      res_q.mapped_x  <= ox_q;
      res_q.mapped_y  <= oy_q;
      res_q.converged <= ok_q;
    end
  end

  rld_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  rld_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign stat_o.mul_done = mul_done;
  assign stat_o.div_done = div_done;
  assign stat_o.a_pos    = t_q > 64'sd0;
  assign stat_o.conv     = conv_q;
  assign stat_o.inverse  = cmd_q;
  assign out_data_o      = res_q;

endmodule

// ===== sv/rld_ctrl.sv =====
module rld_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rld_pkg::stat_t stat_i,
  output rld_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMUL,
    S_CSUB,
    S_SQ,
    S_SSUM,
    S_PMUL,
    S_PWAIT,
    S_EMUL,
    S_EWAIT,
    S_QDIV,
    S_QWAIT,
    S_QNEXT,
    S_STEPCHK,
    S_ODIV,
    S_OWAIT,
    S_OUT
  } state_e;

  state_e                      state_q, state_d;
  logic                        axis_q, axis_d, first_q, first_d;
  logic                        out_valid_q, out_valid_d;
  rld_pkg::ksel_e              kidx_q, kidx_d;
  logic [rld_pkg::ITER_W-1:0]  iter_q, iter_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    first_d     = first_q;
    kidx_d      = kidx_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl_o      = '{op: rld_pkg::OP_IDLE, axis: axis_q, ksel: kidx_q, publish: 1'b0};
    in_ready_o  = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = rld_pkg::OP_LOAD;
          first_d   = 1'b1;
          iter_d    = '0;
          state_d   = S_CMUL;
        end
      end
      S_CMUL: begin
        ctrl_o.op = rld_pkg::OP_CMUL;
        state_d   = S_CSUB;
      end
      S_CSUB: begin
        ctrl_o.op = rld_pkg::OP_CSUB;
        state_d   = S_SQ;
      end
      S_SQ: begin
        ctrl_o.op = rld_pkg::OP_SQ;
        state_d   = S_SSUM;
      end
      S_SSUM: begin
        ctrl_o.op = rld_pkg::OP_SSUM;
        kidx_d    = rld_pkg::KSEL_SECOND;
        state_d   = S_PMUL;
      end
      S_PMUL: begin
        ctrl_o.op = rld_pkg::OP_PMUL;
        state_d   = S_PWAIT;
      end
      S_PWAIT: begin
        if (stat_i.mul_done) begin
          ctrl_o.op = rld_pkg::OP_PADD;
          axis_d    = 1'b0;
          unique case (kidx_q)
            rld_pkg::KSEL_SECOND: begin
              kidx_d  = rld_pkg::KSEL_FIRST;
              state_d = S_PMUL;
            end
            rld_pkg::KSEL_FIRST: begin
              kidx_d  = rld_pkg::KSEL_ONE;
              state_d = S_PMUL;
            end
            default: begin
              state_d = (stat_i.inverse && first_q) ? S_EMUL : S_QDIV;
            end
          endcase
        end
      end
      S_EMUL: begin
        ctrl_o.op = rld_pkg::OP_EMUL;
        state_d   = S_EWAIT;
      end
      S_EWAIT: begin
        if (stat_i.mul_done) begin
          ctrl_o.op = rld_pkg::OP_ESET;
          if (axis_q) begin
            axis_d  = 1'b0;
            first_d = 1'b0;
            state_d = S_SQ;
          end else begin
            axis_d  = 1'b1;
            state_d = S_EMUL;
          end
        end
      end
      S_QDIV: begin
        ctrl_o.op = rld_pkg::OP_QDIV;
        state_d   = S_QWAIT;
      end
      S_QWAIT: begin
        if (stat_i.div_done) begin
          ctrl_o.op = rld_pkg::OP_QSET;
          if (axis_q) begin
            axis_d  = 1'b0;
            state_d = S_QNEXT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_QDIV;
          end
        end
      end
      S_QNEXT: begin
        if (!stat_i.inverse || !stat_i.a_pos) begin
          ctrl_o.op = rld_pkg::OP_FWDSET;
          state_d   = S_ODIV;
        end else begin
          ctrl_o.op = rld_pkg::OP_STEP;
          state_d   = S_STEPCHK;
        end
      end
      S_STEPCHK: begin
        if (stat_i.conv ||
            (iter_q == rld_pkg::ITER_W'(rld_pkg::MAX_ITERATIONS - 1))) begin
          state_d = S_ODIV;
        end else begin
          iter_d  = iter_q + 1'b1;
          state_d = S_SQ;
        end
      end
      S_ODIV: begin
        ctrl_o.op = rld_pkg::OP_ODIV;
        state_d   = S_OWAIT;
      end
      S_OWAIT: begin
        if (stat_i.div_done) begin
          ctrl_o.op = rld_pkg::OP_OSET;
          if (axis_q) begin
            axis_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_ODIV;
          end
        end
      end
      S_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.publish = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      first_q     <= 1'b0;
      kidx_q      <= rld_pkg::KSEL_SECOND;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      first_q     <= first_d;
      kidx_q      <= kidx_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The units only finish while the sequencer waits for them.
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mul_done |-> (state_q == S_PWAIT || state_q == S_EWAIT))
    else $error("multiplier finished outside a wait state");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_QWAIT || state_q == S_OWAIT))
    else $error("divider finished outside a wait state");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still pending");

endmodule

// ===== sv/radial_lens_distortion_mapper.sv =====
// Radial lens distortion mapper.
// Input transactions (in_valid_i/in_ready_o) carry a command bit and a point in
// signed Q16.16 pixels; command 0 applies the three-coefficient radial model,
// command 1 inverts it by fixed-point iteration. Each input gives exactly one
// output transaction (out_valid_o/out_ready_i) with the mapped point and a
// converged flag. Registers are written through cfg_valid_i/cfg_index_i/
// cfg_data_i and are always ready; write them only while the block is idle.
// One item is processed at a time. An inverse item runs up to 64 iterations.
// The bit-serial divider computes the quotients, two per iteration and two for
// output scaling, and the shared multiplier runs the polynomial in Horner form.
// A finished result sits in the output register; the next input is accepted
// while it waits, and that item stalls only when its own result is ready and
// the previous one has not been taken. Reset clears control state and loads
// the registers with zero coefficients, a 1920x1080 frame and a ratio of 1.0.
module radial_lens_distortion_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rld_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rld_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rld_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  rld_pkg::cfg_t  cfg_q;
  rld_pkg::ctrl_t ctrl;
  rld_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_first  <= '0;
      cfg_q.coeff_second <= '0;
      cfg_q.coeff_third  <= '0;
      cfg_q.image_width  <= rld_pkg::WIDTH_RST;
      cfg_q.image_height <= rld_pkg::HEIGHT_RST;
      cfg_q.scale_ratio  <= rld_pkg::RATIO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rld_pkg::REG_COEFF_FIRST:  cfg_q.coeff_first  <= cfg_data_i;
        rld_pkg::REG_COEFF_SECOND: cfg_q.coeff_second <= cfg_data_i;
        rld_pkg::REG_COEFF_THIRD:  cfg_q.coeff_third  <= cfg_data_i;
        rld_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[rld_pkg::SIZE_W-1:0];
        rld_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[rld_pkg::SIZE_W-1:0];
        rld_pkg::REG_SCALE_RATIO:  cfg_q.scale_ratio  <= cfg_data_i[rld_pkg::RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  rld_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
